// ----- rtl/soa_pkg.sv -----
// Shared types, constants and status codes of the slab object allocator.
package soa_pkg;

  localparam int PAGE_BYTES_DEF        = 4096;
  localparam int MAX_PAGES_DEF         = 64;
  localparam int MAX_OBJS_PER_PAGE_DEF = 2048;

  localparam logic [15:0] NO_INDEX  = 16'hFFFF;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [1:0] CFG_OBJECT_SIZE   = 2'd0;
  localparam logic [1:0] CFG_OBJS_PER_PAGE = 2'd1;
  localparam logic [1:0] CFG_POOL_BASE     = 2'd2;
  localparam logic [1:0] CFG_POOL_PAGES    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_NO_PAGES = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR = 3'd3;
  localparam logic [2:0] ST_OVERFULL = 3'd4;

  typedef struct packed {
    logic [15:0] head;
    logic [15:0] bump;
    logic [15:0] avail;
  } page_rec_t;

  typedef struct packed {
    logic       latch;
    logic       claim;
    logic       rd_alloc;
    logic       achk;
    logic       alnk;
    logic       aupd;
    logic       aadr;
    logic       div_start;
    logic       div_step;
    logic       rd_free;
    logic       fupd;
    logic       set_st;
    logic [2:0] st;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_bad;
    logic list_empty;
    logic pool_full;
    logic free_bad;
    logic div_done;
    logic need_link;
    logic idx_bad;
    logic overfull;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/slab_object_allocator_unit.sv -----
// Top level of the slab object allocator: stream ports, sequencer and datapath.
//
// One request enters on the s_axis channel: tuser carries the opcode (0 allocate,
// 1 free), tdata the requested size and the object address. Every request
// yields exactly one result on the m_axis channel with the allocated address,
// a status code and the slot and in-use counts after the request.
// The block works on one request at a time. An allocate passes through an extra
// state when a pool page is claimed or when the reused object's chain link is
// read from memory; the two never coincide. A free runs a restoring divider over
// the page offset, one quotient bit per cycle. Early rejections go straight from
// decoding to the result. The next request is accepted in the cycle after the
// result is loaded into the output register.
// A result waits in the output register while m_axis_tready is low; the block
// then holds its finished request and takes no new one until the result leaves.
// Reset clears the page list, the counters and the claimed-page count and loads
// the register defaults; page tables need no clearing since every entry is
// written when its page is claimed. Configuration is written through cfg_we_i.
module slab_object_allocator_unit import soa_pkg::*; #(
  parameter int PAGE_BYTES        = PAGE_BYTES_DEF,
  parameter int MAX_PAGES         = MAX_PAGES_DEF,
  parameter int MAX_OBJS_PER_PAGE = MAX_OBJS_PER_PAGE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // request_size[15:0], object_address[63:16]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // allocated_address[47:0], status[50:48], total_objects[67:51],
  // allocated_objects[84:68], zero fill[87:85]
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;
  logic [47:0] res_addr;
  logic [2:0]  res_st;
  logic [16:0] res_tot, res_use;

  soa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  soa_dp #(
    .PAGE_BYTES        (PAGE_BYTES),
    .MAX_PAGES         (MAX_PAGES),
    .MAX_OBJS_PER_PAGE (MAX_OBJS_PER_PAGE)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_opcode_i             (s_axis_tuser[0]),
    .in_request_size_i       (s_axis_tdata[15:0]),
    .in_object_address_i     (s_axis_tdata[63:16]),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .out_valid_o             (m_axis_tvalid),
    .out_ready_i             (m_axis_tready),
    .out_allocated_address_o (res_addr),
    .out_status_o            (res_st),
    .out_total_objects_o     (res_tot),
    .out_allocated_objects_o (res_use)
  );

  // The result fields are packed lowest first with zero fill to whole bytes.
  assign m_axis_tdata = {3'b000, res_use, res_tot, res_st, res_addr};

endmodule

// ----- rtl/soa_ctrl.sv -----
// Sequencer that steps one allocate or free request through the datapath.
module soa_ctrl import soa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_CLAIM = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_ACHK  = 4'd4;
  localparam logic [3:0] S_ALNK  = 4'd5;
  localparam logic [3:0] S_AUPD  = 4'd6;
  localparam logic [3:0] S_AADR  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts_i.is_free) begin
          if (sts_i.size_bad) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_SIZE;
            state_d      = S_FIN;
          end else if (sts_i.list_empty) begin
            if (sts_i.pool_full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_NO_PAGES;
              state_d      = S_FIN;
            end else begin
              state_d = S_CLAIM;
            end
          end else begin
            state_d = S_ARD;
          end
        end else if (sts_i.free_bad) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_BAD_ADDR;
          state_d      = S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_CLAIM: begin
        cmd_o.claim = 1'b1;
        state_d     = S_ARD;
      end
      S_ARD: begin
        cmd_o.rd_alloc = 1'b1;
        state_d        = S_ACHK;
      end
      S_ACHK: begin
        cmd_o.achk = 1'b1;
        state_d    = sts_i.need_link ? S_ALNK : S_AUPD;
      end
      S_ALNK: begin
        cmd_o.alnk = 1'b1;
        state_d    = S_AUPD;
      end
      S_AUPD: begin
        cmd_o.aupd = 1'b1;
        state_d    = S_AADR;
      end
      S_AADR: begin
        cmd_o.aadr   = 1'b1;
        cmd_o.set_st = 1'b1;
        cmd_o.st     = ST_OK;
        state_d      = S_FIN;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FCHK;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FCHK: begin
        cmd_o.rd_free = 1'b1;
        if (sts_i.idx_bad) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_BAD_ADDR;
          state_d      = S_FIN;
        end else begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.set_st = 1'b1;
        if (sts_i.overfull) begin
          cmd_o.st = ST_OVERFULL;
        end else begin
          cmd_o.fupd = 1'b1;
          cmd_o.st   = ST_OK;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/soa_dp.sv -----
// Datapath: registers, page tables, object chain memory, divider and result register.
module soa_dp import soa_pkg::*; #(
  parameter int PAGE_BYTES        = PAGE_BYTES_DEF,
  parameter int MAX_PAGES         = MAX_PAGES_DEF,
  parameter int MAX_OBJS_PER_PAGE = MAX_OBJS_PER_PAGE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_opcode_i,
  input  logic [15:0] in_request_size_i,
  input  logic [47:0] in_object_address_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] out_allocated_address_o,
  output logic [2:0]  out_status_o,
  output logic [16:0] out_total_objects_o,
  output logic [16:0] out_allocated_objects_o
);

  localparam int PBW  = $clog2(PAGE_BYTES);
  localparam int PGW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CLW  = $clog2(MAX_PAGES + 1);
  localparam int CW   = (CLW > 7) ? CLW : 7;
  localparam int LD   = MAX_PAGES * MAX_OBJS_PER_PAGE;
  localparam int LAW  = (LD > 1) ? $clog2(LD) : 1;
  localparam int DCW  = $clog2(PBW + 1);
  localparam logic [CLW-1:0] EMPTY = CLW'(MAX_PAGES);
  localparam logic [15:0]    MOPP  = 16'(MAX_OBJS_PER_PAGE);

  // Configuration registers.
  logic [11:0] os_q;
  logic [10:0] opp_q;
  logic [47:0] base_q;
  logic [6:0]  pp_q;

  // Control state.
  logic [CLW-1:0] claimed_q, first_q;
  logic [16:0]    slot_q, use_q;
  logic           out_valid_q;

  // Request and working registers.
  logic        op_q;
  logic [15:0] size_q;
  logic [47:0] oaddr_q;
  logic [PGW-1:0] p_q;
  logic [15:0] idx_q;
  logic [27:0] prod_q;
  page_rec_t   wrec_q;
  logic [47:0] res_addr_q;
  logic [2:0]  st_q;
  logic [11:0] rem_q;
  logic [PBW-1:0] quo_q;
  logic [DCW-1:0] cnt_q;
  logic [47:0] out_addr_q;
  logic [2:0]  out_st_q;
  logic [16:0] out_tot_q, out_use_q;

  // Memories and their registered read data.
  page_rec_t      rec_mem [MAX_PAGES];
  logic [CLW-1:0] nxt_mem [MAX_PAGES];
  logic [15:0]    lnk_mem [LD];
  page_rec_t      rec_rd_q;
  logic [CLW-1:0] nxt_rd_q;
  logic [15:0]    lnk_rd_q;

  function automatic logic [LAW-1:0] lad(logic [PGW-1:0] p, logic [15:0] i);
    return LAW'(32'(p) * MAX_OBJS_PER_PAGE + 32'(i));
  endfunction

  // Effective slot count and pool limit.
  logic [15:0] slots;
  logic [CW-1:0] lim;
  always_comb begin
    if (opp_q == 11'd0) begin
      slots = 16'd1;
    end else if ({5'd0, opp_q} > MOPP) begin
      slots = MOPP;
    end else begin
      slots = {5'd0, opp_q};
    end
    lim = (CW'(pp_q) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pp_q);
  end

  logic [47:0] off;
  logic [47-PBW:0] pg_hi;
  assign off   = oaddr_q - base_q;
  assign pg_hi = off[47:PBW];

  logic [12:0] trial;
  assign trial = {rem_q, quo_q[PBW-1]} - {1'b0, os_q};

  logic [17:0] slot_sum;
  assign slot_sum = 18'(slot_q) + 18'(slots);

  always_comb begin
    sts_o.is_free    = op_q;
    sts_o.size_bad   = size_q != {4'd0, os_q};
    sts_o.list_empty = first_q == EMPTY;
    sts_o.pool_full  = CW'(claimed_q) >= lim;
    sts_o.free_bad   = (os_q == 12'd0) || (pg_hi >= (48 - PBW)'(claimed_q));
    sts_o.div_done   = cnt_q == '0;
    sts_o.need_link  = (rec_rd_q.head != NO_INDEX) && (rec_rd_q.head < MOPP);
    sts_o.idx_bad    = (rem_q != 12'd0) || (16'(quo_q) >= slots);
    sts_o.overfull   = rec_rd_q.avail >= slots;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // Page record after an allocate takes its object; a chained head is
  // replaced by the link value in the next cycle.
  page_rec_t wrec_nx;
  always_comb begin
    wrec_nx       = rec_rd_q;
    wrec_nx.avail = (rec_rd_q.avail != 16'd0) ? rec_rd_q.avail - 16'd1 : 16'd0;
    if (rec_rd_q.head != NO_INDEX) begin
      if (!sts_o.need_link) wrec_nx.head = NO_INDEX;
    end else begin
      wrec_nx.bump = rec_rd_q.bump + 16'd1;
    end
  end

  // Memory ports.
  logic           rec_we, nxt_we, rd_en;
  logic [PGW-1:0] rec_wa, rd_a;
  page_rec_t      rec_wd;
  logic [CLW-1:0] nxt_wd;
  always_comb begin
    rec_we = cmd_i.claim | cmd_i.aupd | cmd_i.fupd;
    rec_wa = cmd_i.claim ? claimed_q[PGW-1:0] : p_q;
    if (cmd_i.claim) begin
      rec_wd = '{head: NO_INDEX, bump: 16'd0, avail: slots};
    end else if (cmd_i.fupd) begin
      rec_wd = '{head: 16'(quo_q), bump: rec_rd_q.bump, avail: rec_rd_q.avail + 16'd1};
    end else begin
      rec_wd = wrec_q;
    end
    nxt_we = cmd_i.claim | (cmd_i.fupd && rec_rd_q.avail == 16'd0);
    nxt_wd = cmd_i.claim ? EMPTY : first_q;
    rd_en  = cmd_i.rd_alloc | cmd_i.rd_free;
    rd_a   = cmd_i.rd_alloc ? first_q[PGW-1:0] : p_q;
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (nxt_we) nxt_mem[rec_wa] <= nxt_wd;
    if (rd_en) begin
      rec_rd_q <= rec_mem[rd_a];
      nxt_rd_q <= nxt_mem[rd_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fupd) lnk_mem[lad(p_q, 16'(quo_q))] <= rec_rd_q.head;
    if (cmd_i.achk) lnk_rd_q <= lnk_mem[lad(p_q, rec_rd_q.head)];
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    prod_q <= idx_q * os_q;
    if (cmd_i.latch) begin
      op_q       <= in_opcode_i;
      size_q     <= in_request_size_i;
      oaddr_q    <= in_object_address_i;
      res_addr_q <= '0;
    end
    if (cmd_i.rd_alloc) p_q <= first_q[PGW-1:0];
    if (cmd_i.div_start) begin
      p_q   <= pg_hi[PGW-1:0];
      rem_q <= '0;
      quo_q <= off[PBW-1:0];
      cnt_q <= DCW'(PBW);
    end
    if (cmd_i.div_step) begin
      if (!trial[12]) begin
        rem_q <= trial[11:0];
        quo_q <= {quo_q[PBW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[10:0], quo_q[PBW-1]};
        quo_q <= {quo_q[PBW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - DCW'(1);
    end
    if (cmd_i.achk) begin
      wrec_q <= wrec_nx;
      idx_q  <= (rec_rd_q.head != NO_INDEX) ? rec_rd_q.head : rec_rd_q.bump;
    end
    if (cmd_i.alnk) wrec_q.head <= lnk_rd_q;
    if (cmd_i.aadr) res_addr_q <= base_q + (48'(p_q) << PBW) + 48'(prod_q);
    if (cmd_i.set_st) st_q <= cmd_i.st;
    if (cmd_i.load_out) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= st_q;
      out_tot_q  <= slot_q;
      out_use_q  <= use_q;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_q        <= 12'd64;
      opp_q       <= 11'd63;
      base_q      <= '0;
      pp_q        <= 7'd64;
      claimed_q   <= '0;
      first_q     <= EMPTY;
      slot_q      <= '0;
      use_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OBJECT_SIZE:   os_q   <= cfg_wdata_i[11:0];
          CFG_OBJS_PER_PAGE: opp_q  <= cfg_wdata_i[10:0];
          CFG_POOL_BASE:     base_q <= cfg_wdata_i;
          CFG_POOL_PAGES:    pp_q   <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.claim) begin
        first_q   <= claimed_q;
        claimed_q <= claimed_q + CLW'(1);
        slot_q    <= slot_sum[17] ? COUNT_MAX : slot_sum[16:0];
      end
      if (cmd_i.aupd) begin
        if (wrec_q.avail == 16'd0) first_q <= nxt_rd_q;
        if (use_q != COUNT_MAX) use_q <= use_q + 17'd1;
      end
      if (cmd_i.fupd) begin
        if (rec_rd_q.avail == 16'd0) first_q <= CLW'(p_q);
        if (use_q != 17'd0) use_q <= use_q - 17'd1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_allocated_address_o = out_addr_q;
  assign out_status_o            = out_st_q;
  assign out_total_objects_o     = out_tot_q;
  assign out_allocated_objects_o = out_use_q;

`ifndef SYNTH
  a_claim_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |-> first_q == EMPTY) else $error("claim with a non-empty list");
  a_first_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q <= EMPTY) else $error("list head out of range");
  a_claimed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(claimed_q) <= CW'(MAX_PAGES)) else $error("claimed page count overflow");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q) else $error("result not presented");
`endif

endmodule

// ----- test/slab_object_allocator_unit_tb.sv -----
// Self-checking testbench of the slab object allocator: directed table, then random phases.
module slab_object_allocator_unit_tb;
  import soa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode values carried on s_axis_tuser.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int PHASE_ITEMS = 55;
  localparam int N_PHASES    = 8;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_wdata_i;

  slab_object_allocator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // One result of the allocator, as the output stream carries it.
  typedef struct {
    logic [47:0] addr;
    logic [2:0]  status;
    logic [16:0] total;
    logic [16:0] in_use;
  } alloc_result_t;

  // One row of the directed table. When known is set, the expected result is
  // taken from the row instead of the predictor.
  typedef struct {
    logic          op;
    logic [15:0]   size;
    logic [47:0]   addr;
    bit            known;
    alloc_result_t res;
  } directed_row_t;

  // Shadow copy of the configuration registers.
  logic [11:0] sh_obj_size;
  logic [10:0] sh_objs_per_page;
  logic [47:0] sh_pool_base;
  logic [6:0]  sh_pool_pages;

  // Shadow copy of the allocator state.
  int unsigned pages_taken;
  logic [15:0] pg_chain_head [MAX_PAGES_DEF];
  logic [15:0] pg_bump       [MAX_PAGES_DEF];
  logic [15:0] pg_avail      [MAX_PAGES_DEF];
  int unsigned open_head;
  int unsigned open_next [MAX_PAGES_DEF];
  int unsigned open_prev [MAX_PAGES_DEF];
  logic [15:0] obj_link  [MAX_PAGES_DEF * MAX_OBJS_PER_PAGE_DEF];
  int unsigned slots_sum;
  int unsigned used_sum;

  alloc_result_t pending_results[$];
  logic [47:0]   live_addrs[$];
  directed_row_t dir_rows[14];

  int  n_fail;
  int  stall_left;
  int  cycles;
  bit  no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned slots_per_page();
    int unsigned s;
    s = 32'(sh_objs_per_page);
    if (s == 0) s = 1;
    if (s > MAX_OBJS_PER_PAGE_DEF) s = MAX_OBJS_PER_PAGE_DEF;
    return s;
  endfunction

  function automatic void open_push(int unsigned p);
    open_next[p] = open_head;
    open_prev[p] = MAX_PAGES_DEF;
    if (open_head < MAX_PAGES_DEF) open_prev[open_head] = p;
    open_head = p;
  endfunction

  function automatic void shadow_reset();
    sh_obj_size      = 12'd64;
    sh_objs_per_page = 11'd63;
    sh_pool_base     = '0;
    sh_pool_pages    = 7'd64;
    pages_taken      = 0;
    open_head        = MAX_PAGES_DEF;
    slots_sum        = 0;
    used_sum         = 0;
  endfunction

  // Allocate: status code, address returned through addr.
  function automatic logic [2:0] predict_alloc(logic [15:0] size, output logic [47:0] addr);
    int unsigned slots, lim, p, idx;
    slots = slots_per_page();
    lim = (sh_pool_pages > 7'(MAX_PAGES_DEF)) ? MAX_PAGES_DEF : 32'(sh_pool_pages);
    addr = '0;
    if (size != {4'd0, sh_obj_size}) return ST_SIZE;
    if (open_head >= MAX_PAGES_DEF) begin
      if (pages_taken >= lim) return ST_NO_PAGES;
      p = pages_taken;
      pg_chain_head[p] = NO_INDEX;
      pg_bump[p] = '0;
      pg_avail[p] = slots[15:0];
      open_push(p);
      slots_sum = slots_sum + slots;
      if (slots_sum > COUNT_MAX) slots_sum = 32'(COUNT_MAX);
      pages_taken++;
    end
    p = open_head;
    if (pg_chain_head[p] != NO_INDEX) begin
      idx = 32'(pg_chain_head[p]);
      pg_chain_head[p] = (idx < MAX_OBJS_PER_PAGE_DEF) ?
                         obj_link[p * MAX_OBJS_PER_PAGE_DEF + idx] : NO_INDEX;
    end else begin
      idx = 32'(pg_bump[p]);
      pg_bump[p] = pg_bump[p] + 16'd1;
    end
    if (pg_avail[p] > 0) pg_avail[p]--;
    if (pg_avail[p] == 0) begin
      // A full page leaves the open list.
      open_head = open_next[p];
      if (open_head < MAX_PAGES_DEF) open_prev[open_head] = MAX_PAGES_DEF;
    end
    if (used_sum < COUNT_MAX) used_sum++;
    addr = sh_pool_base + 48'(p) * 48'(PAGE_BYTES_DEF) + 48'(idx) * 48'(sh_obj_size);
    return ST_OK;
  endfunction

  function automatic logic [2:0] predict_free(logic [47:0] a);
    int unsigned slots, pg, idx;
    logic [47:0] off;
    logic [35:0] pg_num;
    logic [11:0] pg_off;
    slots = slots_per_page();
    if (sh_obj_size == 0) return ST_BAD_ADDR;
    off = a - sh_pool_base;
    pg_num = off[47:12];
    pg_off = off[11:0];
    if (pg_num >= 36'(pages_taken)) return ST_BAD_ADDR;
    if (pg_off % sh_obj_size != 0) return ST_BAD_ADDR;
    idx = 32'(pg_off / sh_obj_size);
    if (idx >= slots) return ST_BAD_ADDR;
    pg = 32'(pg_num);
    if (pg_avail[pg] >= slots) return ST_OVERFULL;
    // A page that was full comes back to the head of the open list.
    if (pg_avail[pg] == 0) open_push(pg);
    obj_link[pg * MAX_OBJS_PER_PAGE_DEF + idx] = pg_chain_head[pg];
    pg_chain_head[pg] = idx[15:0];
    pg_avail[pg]++;
    if (used_sum > 0) used_sum--;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_request(logic op, logic [15:0] size,
                                                    logic [47:0] a);
    alloc_result_t r;
    logic [47:0] got;
    got = '0;
    if (op == OP_ALLOC) r.status = predict_alloc(size, got);
    else r.status = predict_free(a);
    r.addr   = (r.status == ST_OK) ? got : '0;
    r.total  = slots_sum[16:0];
    r.in_use = used_sum[16:0];
    return r;
  endfunction

  // Sends one request after a random gap unless no_idle is set; returns at the accepting edge.
  task automatic send_request(logic op, logic [15:0] size, logic [47:0] a,
                              bit known, alloc_result_t typed);
    int gap;
    alloc_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    r = predict_request(op, size, a);
    if (op == OP_ALLOC && r.status == ST_OK) live_addrs.push_back(r.addr);
    pending_results.push_back(known ? typed : r);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {a, size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Lets the block drain completely before configuration is touched.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_OBJECT_SIZE:   sh_obj_size      = val[11:0];
      CFG_OBJS_PER_PAGE: sh_objs_per_page = val[10:0];
      CFG_POOL_BASE:     sh_pool_base     = val;
      CFG_POOL_PAGES:    sh_pool_pages    = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Output side: random stalls unless no_idle is set, and every result is checked
  // against the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        n_fail++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[47:0] !== exp_r.addr) begin
          $error("allocated_address expected %h got %h", exp_r.addr, m_axis_tdata[47:0]);
          n_fail++;
        end
        if (m_axis_tdata[50:48] !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, m_axis_tdata[50:48]);
          n_fail++;
        end
        if (m_axis_tdata[67:51] !== exp_r.total) begin
          $error("total_objects expected %0d got %0d", exp_r.total, m_axis_tdata[67:51]);
          n_fail++;
        end
        if (m_axis_tdata[84:68] !== exp_r.in_use) begin
          $error("allocated_objects expected %0d got %0d", exp_r.in_use,
                 m_axis_tdata[84:68]);
          n_fail++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 15);
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic          op;
    logic [15:0]   size;
    logic [47:0]   a;
    logic [47:0]   ph_base;
    logic [11:0]   ph_size;
    logic [10:0]   ph_opp;
    logic [6:0]    ph_pages;
    alloc_result_t none;
    int            r;
    int            k;

    n_fail = 0;
    stall_left = 0;
    cycles = 0;
    no_idle = 1'b0;
    none = '{48'd0, ST_OK, 17'd0, 17'd0};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OBJECT_SIZE;
    cfg_wdata_i = '0;
    shadow_reset();

    // Directed rows at the reset defaults: 64-byte objects, 63 per page.
    dir_rows[0]  = '{OP_ALLOC, 16'd64,    48'd0,   1, '{48'd0, ST_OK,       17'd63, 17'd1}};
    dir_rows[1]  = '{OP_ALLOC, 16'd63,    48'd0,   1, '{48'd0, ST_SIZE,     17'd63, 17'd1}};
    dir_rows[2]  = '{OP_ALLOC, 16'hFFFF,  '1,      1, '{48'd0, ST_SIZE,     17'd63, 17'd1}};
    dir_rows[3]  = '{OP_FREE,  16'hFFFF,  48'd0,   1, '{48'd0, ST_OK,       17'd63, 17'd0}};
    dir_rows[4]  = '{OP_FREE,  16'd0,     48'd0,   1, '{48'd0, ST_OVERFULL, 17'd63, 17'd0}};
    dir_rows[5]  = '{OP_FREE,  16'd64,    48'd32,  1, '{48'd0, ST_BAD_ADDR, 17'd63, 17'd0}};
    dir_rows[6]  = '{OP_FREE,  16'd64,    48'd4096, 1, '{48'd0, ST_BAD_ADDR, 17'd63, 17'd0}};
    dir_rows[7]  = '{OP_FREE,  16'd64,    48'd4032, 1, '{48'd0, ST_BAD_ADDR, 17'd63, 17'd0}};
    dir_rows[8]  = '{OP_FREE,  16'd64,    '1,      1, '{48'd0, ST_BAD_ADDR, 17'd63, 17'd0}};
    dir_rows[9]  = '{OP_ALLOC, 16'd64,    '1,      1, '{48'd0, ST_OK,       17'd63, 17'd1}};
    dir_rows[10] = '{OP_ALLOC, 16'd64,    48'd0,   0, none};
    dir_rows[11] = '{OP_ALLOC, 16'd0,     48'd0,   1, '{48'd0, ST_SIZE,     17'd63, 17'd2}};
    dir_rows[12] = '{OP_FREE,  16'd0,     48'd64,  0, none};
    dir_rows[13] = '{OP_ALLOC, 16'd64,    48'd0,   0, none};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].size, dir_rows[i].addr,
                   dir_rows[i].known, dir_rows[i].res);
    live_addrs.delete();
    live_addrs.push_back(48'd64);

    // Random phases; each one first drains the block and then rewrites every
    // register, walking through the extremes before random settings.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin ph_size = 12'd64;   ph_opp = 11'd63;   ph_base = '0;              ph_pages = 7'd64;  end
        1: begin ph_size = 12'd2;    ph_opp = 11'd2036; ph_base = 48'hFFFFFFFFF000; ph_pages = 7'd64;  end
        2: begin ph_size = 12'd4072; ph_opp = 11'd1;    ph_base = 48'h123456789000; ph_pages = 7'd3;   end
        3: begin ph_size = 12'd0;    ph_opp = 11'd0;    ph_base = '0;              ph_pages = 7'd0;   end
        4: begin ph_size = 12'd4095; ph_opp = 11'd2047; ph_base = '1;              ph_pages = 7'd127; end
        5: begin ph_size = 12'd16;   ph_opp = 11'd4;    ph_base = 48'h000080000000; ph_pages = 7'd10;  end
        default: begin
          ph_size  = 12'($urandom_range(1, 4095));
          ph_opp   = 11'($urandom_range(0, 2047));
          ph_base  = 48'({$urandom, $urandom}) & 48'hFFFFFFFFF000;
          ph_pages = 7'($urandom_range(0, 127));
        end
      endcase
      wait_drained();
      write_reg(CFG_OBJECT_SIZE,   {36'd0, ph_size});
      write_reg(CFG_OBJS_PER_PAGE, {37'd0, ph_opp});
      write_reg(CFG_POOL_BASE,     ph_base);
      write_reg(CFG_POOL_PAGES,    {41'd0, ph_pages});
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        a = 48'({$urandom, $urandom});
        size = 16'($urandom);
        if (r < 55) begin
          op = OP_ALLOC;
          if ($urandom_range(0, 9) != 0) size = {4'd0, sh_obj_size};
        end else begin
          op = OP_FREE;
          if (live_addrs.size() > 0 && r < 85) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[k];
            live_addrs.delete(k);
          end else if (r < 93) begin
            // Near-miss addresses inside or just past the claimed pages.
            a = sh_pool_base + 48'($urandom_range(0, pages_taken)) * 48'(PAGE_BYTES_DEF)
                + 48'($urandom_range(0, 15)) * 48'(sh_obj_size) + 48'($urandom_range(0, 1));
          end
        end
        send_request(op, size, a, 0, none);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
